### src/rtsm_pkg.sv
// Shared constants and types for the row times small matrix block.
package rtsm_pkg;

    // Fixed number of row elements carried by one beat.
    localparam int NUM_FIELDS = 6;

    // Configuration register port.
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS   = 1'd1;

    localparam logic [CFG_W-1:0] INNER_SIZE_RESET = 3'd6;
    localparam logic [CFG_W-1:0] OUT_COLS_RESET   = 3'd6;

    // Input item opcodes.
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_MULTIPLY = 1'b1;

    // Width of the row_index field.
    localparam int ROW_IDX_W = 3;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } rtsm_state_t;

endpackage

### src/rtsm_row_if.sv
// Input channel: one left row or one right-matrix row per beat.
interface rtsm_row_if #(
    parameter int ELEM_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [2:0]                   row_index;
    logic                         last_row;
    logic signed [ELEM_WIDTH-1:0] a0;
    logic signed [ELEM_WIDTH-1:0] a1;
    logic signed [ELEM_WIDTH-1:0] a2;
    logic signed [ELEM_WIDTH-1:0] a3;
    logic signed [ELEM_WIDTH-1:0] a4;
    logic signed [ELEM_WIDTH-1:0] a5;

    modport source (
        output valid, opcode, row_index, last_row, a0, a1, a2, a3, a4, a5,
        input  ready
    );

    modport sink (
        input  valid, opcode, row_index, last_row, a0, a1, a2, a3, a4, a5,
        output ready
    );
endinterface

### src/rtsm_prod_if.sv
// Output channel: one product row per beat.
interface rtsm_prod_if #(
    parameter int ELEM_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] c0;
    logic signed [ELEM_WIDTH-1:0] c1;
    logic signed [ELEM_WIDTH-1:0] c2;
    logic signed [ELEM_WIDTH-1:0] c3;
    logic signed [ELEM_WIDTH-1:0] c4;
    logic signed [ELEM_WIDTH-1:0] c5;
    logic                         row_done_last;

    modport source (
        output valid, c0, c1, c2, c3, c4, c5, row_done_last,
        input  ready
    );

    modport sink (
        input  valid, c0, c1, c2, c3, c4, c5, row_done_last,
        output ready
    );
endinterface

### src/rtsm_cell.sv
// Column cell: holds one right-matrix column, multiplies and accumulates.
module rtsm_cell #(
    parameter int ELEM_WIDTH = 32,
    parameter int LANES      = 6,
    parameter int ACC_W      = 67
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load_en,
    input  logic [$clog2(LANES)-1:0]      load_row,
    input  logic signed [ELEM_WIDTH-1:0]  load_data,
    input  logic                          clear,
    input  logic                          in_valid,
    input  logic [$clog2(LANES)-1:0]      in_k,
    input  logic signed [ELEM_WIDTH-1:0]  in_a,
    output logic                          out_valid,
    output logic [$clog2(LANES)-1:0]      out_k,
    output logic signed [ELEM_WIDTH-1:0]  out_a,
    output logic signed [ACC_W-1:0]       acc
);
    localparam int KW = $clog2(LANES);
    localparam int PW = 2 * ELEM_WIDTH;

    logic signed [ELEM_WIDTH-1:0] col_reg [LANES];
    logic signed [PW-1:0]         a_ext;
    logic signed [PW-1:0]         b_ext;
    logic signed [PW-1:0]         prod_next;
    logic signed [PW-1:0]         prod_reg;
    logic                         prod_valid_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic                         hand_valid_reg;
    logic [KW-1:0]                hand_k_reg;
    logic signed [ELEM_WIDTH-1:0] hand_a_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            col_reg[load_row] <= load_data;
        end
    end

    assign a_ext     = PW'(in_a);
    assign b_ext     = PW'(col_reg[in_k]);
    assign prod_next = a_ext * b_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            hand_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            hand_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        hand_k_reg <= in_k;
        hand_a_reg <= in_a;
        if (clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign out_valid = hand_valid_reg;
    assign out_k     = hand_k_reg;
    assign out_a     = hand_a_reg;
    assign acc       = acc_reg;
endmodule

### src/row_times_small_matrix.sv
// Top level: row sequencer, column cell chain and product output register.
//
//  channel   dir  beat carries
//  rows      in   opcode, row_index, last_row, a0..a5
//  products  out  c0..c5, row_done_last
//  cfg_*     in   register write: cfg_we, cfg_index, cfg_data
//
// A load beat writes one right-matrix row into all cells.
// A multiply beat holds rows.ready low from its accepting edge until its run ends,
// with n = min(inner_size, LANES) row elements fed; the product beat is valid from
// the cycle rows.ready rises.
// Row elements enter the cell chain one per cycle and ripple across LANES cells.
// rows.ready is high whenever the sequencer is idle, even while a product
// beat still waits in the output register; a stalled product holds the
// sequencer at the end of its run. Reset clears control state only.
module row_times_small_matrix
    import rtsm_pkg::*;
#(
    parameter int MAX_DIM    = 6,
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    rtsm_row_if.sink             rows,
    rtsm_prod_if.source          products
);
    localparam int LANES = (MAX_DIM < NUM_FIELDS) ? MAX_DIM : NUM_FIELDS;
    localparam int KW    = $clog2(LANES);
    localparam int NW    = $clog2(LANES + 1);
    localparam int CW    = $clog2(2 * LANES + 2);
    localparam int ACC_W = 2 * ELEM_WIDTH + $clog2(LANES);

    rtsm_state_t state_reg, state_next;

    logic [CFG_W-1:0]             inner_size_reg;
    logic [CFG_W-1:0]             out_cols_reg;
    logic [NW-1:0]                n_reg;
    logic [NW-1:0]                m_reg;
    logic [NW-1:0]                n_sat;
    logic [NW-1:0]                m_sat;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         last_reg;
    logic signed [ELEM_WIDTH-1:0] row_reg [LANES];
    logic signed [ELEM_WIDTH-1:0] a_in [NUM_FIELDS];

    logic                         out_valid_reg, out_valid_next;
    logic signed [ELEM_WIDTH-1:0] c_reg [NUM_FIELDS];
    logic                         done_last_reg;
    logic signed [ELEM_WIDTH-1:0] c_res [NUM_FIELDS];

    logic                         accept;
    logic                         start_mul;
    logic                         load_en;
    logic                         feed;
    logic                         finish;
    logic                         at_end;

    logic                         ch_valid [LANES+1];
    logic [KW-1:0]                ch_k     [LANES+1];
    logic signed [ELEM_WIDTH-1:0] ch_a     [LANES+1];
    logic signed [ACC_W-1:0]      acc      [LANES];

    assign a_in[0] = rows.a0;
    assign a_in[1] = rows.a1;
    assign a_in[2] = rows.a2;
    assign a_in[3] = rows.a3;
    assign a_in[4] = rows.a4;
    assign a_in[5] = rows.a5;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_size_reg <= INNER_SIZE_RESET;
            out_cols_reg   <= OUT_COLS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INNER_SIZE: inner_size_reg <= cfg_data;
                REG_OUT_COLS:   out_cols_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp sizes to the number of cells
    assign n_sat = (inner_size_reg > CFG_W'(LANES)) ? NW'(LANES) : NW'(inner_size_reg);
    assign m_sat = (out_cols_reg > CFG_W'(LANES)) ? NW'(LANES) : NW'(out_cols_reg);

    assign rows.ready = (state_reg == ST_IDLE);
    assign accept     = rows.valid && rows.ready;
    assign start_mul  = accept && (rows.opcode == OP_MULTIPLY);
    assign load_en    = accept && (rows.opcode == OP_LOAD)
                        && (rows.row_index < ROW_IDX_W'(LANES));

    assign feed   = (state_reg == ST_RUN) && (cnt_reg < CW'(n_reg));
    assign at_end = (cnt_reg == (CW'(n_reg) + CW'(LANES)));
    assign finish = (state_reg == ST_RUN) && at_end && (!out_valid_reg || products.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (products.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_mul)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
                else if (!at_end)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Latch the left row and the clamped sizes for the run
    always_ff @(posedge clk)
    begin
        if (start_mul)
        begin
            n_reg    <= n_sat;
            m_reg    <= m_sat;
            last_reg <= rows.last_row;
            for (int j = 0; j < LANES; j++)
            begin
                row_reg[j] <= a_in[j];
            end
        end
    end

    assign ch_valid[0] = feed;
    assign ch_k[0]     = cnt_reg[KW-1:0];
    assign ch_a[0]     = row_reg[cnt_reg[KW-1:0]];

    for (genvar j = 0; j < LANES; j++)
    begin : g_cell
        rtsm_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .LANES      (LANES),
            .ACC_W      (ACC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load_en   (load_en),
            .load_row  (rows.row_index[KW-1:0]),
            .load_data (a_in[j]),
            .clear     (start_mul),
            .in_valid  (ch_valid[j]),
            .in_k      (ch_k[j]),
            .in_a      (ch_a[j]),
            .out_valid (ch_valid[j+1]),
            .out_k     (ch_k[j+1]),
            .out_a     (ch_a[j+1]),
            .acc       (acc[j])
        );
    end

    // Drop fraction bits, saturate, zero columns past out_cols
    for (genvar j = 0; j < NUM_FIELDS; j++)
    begin : g_res
        if (j < LANES)
        begin : g_live
            logic signed [ACC_W-1:0]      shifted;
            logic                         fits;
            logic signed [ELEM_WIDTH-1:0] res;
            assign shifted = acc[j] >>> FRAC_BITS;
            assign fits    = (&shifted[ACC_W-1:ELEM_WIDTH-1])
                             || !(|shifted[ACC_W-1:ELEM_WIDTH-1]);
            always_comb
            begin
                priority if (NW'(j) >= m_reg)
                begin
                    res = '0;
                end
                else if (fits)
                begin
                    res = shifted[ELEM_WIDTH-1:0];
                end
                else if (shifted[ACC_W-1])
                begin
                    res = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
                end
                else
                begin
                    res = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
                end
            end
            assign c_res[j] = res;
        end
        else
        begin : g_zero
            assign c_res[j] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            done_last_reg <= last_reg;
            for (int j = 0; j < NUM_FIELDS; j++)
            begin
                c_reg[j] <= c_res[j];
            end
        end
    end

    assign products.valid         = out_valid_reg;
    assign products.c0            = c_reg[0];
    assign products.c1            = c_reg[1];
    assign products.c2            = c_reg[2];
    assign products.c3            = c_reg[3];
    assign products.c4            = c_reg[4];
    assign products.c5            = c_reg[5];
    assign products.row_done_last = done_last_reg;
endmodule
